// File: hw/rtl/slot_bitmap_allocator_core_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; included by the modules that carry checks
`ifndef SLOT_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define SLOT_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sba: invariant violated");
`define SBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sba: same-cycle implication violated");
`define SBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sba: next-cycle implication violated");
`else
`define SBA_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/sba_pkg.sv
// types, codes and constants of the slot bitmap allocator
// no dependencies
package sba_pkg;

    localparam int unsigned ADDR_W      = 48;
    localparam int unsigned REQ_W       = 32;
    localparam int unsigned SIZE_W      = 13;
    localparam int unsigned ESIZE_W     = 14;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned LIM_W       = 23;
    localparam int unsigned STAT_W      = 32;
    localparam int unsigned IDX_OUT_W   = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BIT_W       = 5;
    localparam int unsigned REG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;
    localparam int unsigned DIV_STEPS   = 9;
    localparam int unsigned STEP_W      = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOT_SIZE  = 2'd0,
        REG_SLOT_COUNT = 2'd1,
        REG_ARENA_BASE = 2'd2
    } reg_idx_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        RSP_GIVEN    = 3'd0,
        RSP_ALLOC_FB = 3'd1,
        RSP_FREED    = 3'd2,
        RSP_FREE_FB  = 3'd3,
        RSP_IGNORED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_ALLOC_MISS,
        OP_FREE,
        OP_FREE_MISS,
        OP_IGNORE
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MUL,
        ST_DIV,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_RESP
    } back_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [REQ_W-1:0]    request_size;
        logic [ADDR_W-1:0]   address;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    slot_address;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [COUNT_W-1:0]   slots_in_use;
        logic [STAT_W-1:0]    alloc_total;
        logic [STAT_W-1:0]    free_total;
        logic [STAT_W-1:0]    alloc_hit_total;
        logic [STAT_W-1:0]    alloc_miss_total;
        logic [STAT_W-1:0]    free_hit_total;
        logic [STAT_W-1:0]    free_miss_total;
    } rsp_t;

    // derived configuration seen by front and back
    typedef struct packed {
        logic [ESIZE_W-1:0] eff_size;
        logic [COUNT_W-1:0] eff_count;
        logic [LIM_W-1:0]   limit;
        logic [ADDR_W-1:0]  base;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [LIM_W-1:0] offset;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] addr_mask_f(input int unsigned bits);
        logic [63:0] m;
        if (bits >= 64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << bits) - 64'd1;
        end
        return m[ADDR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/slot_bitmap_allocator_core.sv
// slot bitmap allocator top level: config block, front end, queue and back end
// depends on sba_pkg, sba_cfg, sba_front, sba_queue and sba_back
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  req      | req_valid, req_ready, req (in_item_t)     | in
//  rsp      | rsp_valid, rsp_ready, rsp (rsp_t)         | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// back end: an allocate reads and checks each 32-slot word in turn, then multiplies slot by size;
// a free runs the 9-step shift-subtract divide, then reads the slot's word and clears its bit;
// fallbacks and ignored frees go straight to the result. The front register and two-entry queue
// sit ahead of that and keep taking beats while a result waits in the output register, until they fill
// reset: bitmap reads as all free at once through per-word valid bits, no sweep
module slot_bitmap_allocator_core #(
    parameter int unsigned MAX_SLOTS = 256,
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  sba_pkg::in_item_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output sba_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sba_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]    cfg_data
);
    import sba_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic q_full;
    logic pop;
    logic head_valid;

    sba_cfg #(
        .MAX_SLOTS (MAX_SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sba_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    sba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sba_back #(
        .MAX_SLOTS (MAX_SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// File: hw/rtl/sba_cfg.sv
// configuration registers and the values derived from them
// depends on sba_pkg
module sba_cfg #(
    parameter int unsigned MAX_SLOTS = 256,
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sba_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]       cfg_data,
    output sba_pkg::cfg_t                    cfg
);
    import sba_pkg::*;

    localparam logic [ADDR_W-1:0]  ADDR_MASK = addr_mask_f(ADDR_BITS);
    localparam logic [COUNT_W-1:0] RST_COUNT =
        (MAX_SLOTS < 256) ? COUNT_W'(MAX_SLOTS) : COUNT_W'(256);
    localparam logic [LIM_W-1:0]   RST_LIMIT = LIM_W'(RST_COUNT * 128);

    logic [SIZE_W-1:0]  slot_bytes_reg;
    logic [COUNT_W-1:0] slot_count_reg;
    logic [ADDR_W-1:0]  arena_base_reg;
    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [ESIZE_W-1:0] size_raw;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        // zero size behaves as one byte, then round up to eight
        size_raw = (slot_bytes_reg == '0) ? ESIZE_W'(1) : ESIZE_W'(slot_bytes_reg);
        cfg_next.eff_size = (size_raw + ESIZE_W'(7)) & ~ESIZE_W'(7);
        if (16'(slot_count_reg) > 16'(MAX_SLOTS))
        begin
            cfg_next.eff_count = COUNT_W'(MAX_SLOTS);
        end
        else
        begin
            cfg_next.eff_count = slot_count_reg;
        end
        cfg_next.limit = LIM_W'(LIM_W'(cfg_next.eff_count) * LIM_W'(cfg_next.eff_size));
        cfg_next.base  = arena_base_reg & ADDR_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bytes_reg    <= SIZE_W'(128);
            slot_count_reg    <= COUNT_W'(256);
            arena_base_reg    <= '0;
            cfg_reg.eff_size  <= ESIZE_W'(128);
            cfg_reg.eff_count <= RST_COUNT;
            cfg_reg.limit     <= RST_LIMIT;
            cfg_reg.base      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SLOT_SIZE:  slot_bytes_reg <= cfg_data[SIZE_W-1:0];
                    REG_SLOT_COUNT: slot_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_ARENA_BASE: arena_base_reg <= cfg_data;
                    default:        ;
                endcase
            end
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/sba_front.sv
// front end: takes request beats and sorts them into commands for the back end
// depends on sba_pkg
module sba_front #(
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sba_pkg::in_item_t req,
    input  sba_pkg::cfg_t     cfg,
    input  logic              q_full,
    output logic              push,
    output sba_pkg::cmd_t     push_cmd
);
    import sba_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask_f(ADDR_BITS);

    logic              stage_valid_reg;
    in_item_t          stage_item_reg;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] diff;

    assign push      = stage_valid_reg && !q_full;
    assign req_ready = !stage_valid_reg || !q_full;

    always_comb
    begin
        addr            = stage_item_reg.address & ADDR_MASK;
        diff            = addr - cfg.base;
        push_cmd.offset = diff[LIM_W-1:0];
        if (stage_item_reg.kind == KIND_ALLOC)
        begin
            push_cmd.op = (stage_item_reg.request_size <= REQ_W'(cfg.eff_size))
                          ? OP_ALLOC : OP_ALLOC_MISS;
        end
        else if (addr == '0)
        begin
            push_cmd.op = OP_IGNORE;
        end
        else if (addr < cfg.base)
        begin
            push_cmd.op = OP_FREE_MISS;
        end
        else if (diff < ADDR_W'(cfg.limit))
        begin
            // inside the active slots, the divide only has to find which one
            push_cmd.op = OP_FREE;
        end
        else
        begin
            push_cmd.op = OP_FREE_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_item_reg <= req;
        end
    end

endmodule

// File: hw/rtl/sba_queue.sv
// two-entry command queue between front and back end
// depends on sba_pkg and the assertion macro header
`include "slot_bitmap_allocator_core_macros.svh"
module sba_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sba_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sba_pkg::cmd_t head
);
    import sba_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SBA_ASSERT_ALWAYS(a_q_bound, clk, rst_n, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `SBA_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !full || pop)
    `SBA_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_reg != '0)

endmodule

// File: hw/rtl/sba_back.sv
// back end: bitmap scan, slot divide, bitmap update, statistics and result register
// depends on sba_pkg and the assertion macro header
`include "slot_bitmap_allocator_core_macros.svh"
module sba_back #(
    parameter int unsigned MAX_SLOTS = 256,
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sba_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  sba_pkg::cmd_t head,
    output logic          pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sba_pkg::rsp_t rsp
);
    import sba_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask_f(ADDR_BITS);
    // a 9-bit slot count never reaches more than 511 slots
    localparam int unsigned USE_SLOTS = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
    localparam int unsigned NUM_WORDS = (USE_SLOTS + WORD_W - 1) / WORD_W;
    localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned MEM_DEPTH = 1 << WORD_AW;
    localparam int unsigned NS_W      = COUNT_W + 1;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    back_state_t         state_reg;
    back_state_t         state_next;
    status_t             status_reg;
    status_t             status_next;
    logic [WORD_AW-1:0]  word_reg;
    logic [WORD_AW-1:0]  word_next;
    logic [COUNT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0]  slot_next;
    logic [LIM_W-1:0]    rem_reg;
    logic [LIM_W-1:0]    rem_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [LIM_W-1:0]    prod_reg;
    logic [LIM_W-1:0]    prod_next;

    logic [WORD_W-1:0]   bitmap_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] word_valid_reg;
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic [WORD_AW-1:0]  raddr;
    logic                mem_we;
    logic [WORD_AW-1:0]  mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [COUNT_W-1:0]  used_reg;
    logic [COUNT_W-1:0]  used_next;
    logic [STAT_W-1:0]   alloc_total_reg;
    logic [STAT_W-1:0]   alloc_total_next;
    logic [STAT_W-1:0]   free_total_reg;
    logic [STAT_W-1:0]   free_total_next;
    logic [STAT_W-1:0]   alloc_hit_reg;
    logic [STAT_W-1:0]   alloc_hit_next;
    logic [STAT_W-1:0]   alloc_miss_reg;
    logic [STAT_W-1:0]   alloc_miss_next;
    logic [STAT_W-1:0]   free_hit_reg;
    logic [STAT_W-1:0]   free_hit_next;
    logic [STAT_W-1:0]   free_miss_reg;
    logic [STAT_W-1:0]   free_miss_next;

    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                fire;

    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   avail;
    logic                found;
    logic [BIT_W-1:0]    found_bit;
    logic [COUNT_W-1:0]  cand_slot;
    logic [NS_W-1:0]     next_start;
    logic                scan_end;
    logic [LIM_W-1:0]    shifted;
    logic [WORD_AW-1:0]  slot_word;
    logic                free_bit;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // words never written read as all free
    assign rd_word   = rd_valid_reg ? rd_data_reg : '0;
    assign slot_word = WORD_AW'(slot_reg >> BIT_W);
    assign free_bit  = rd_word[slot_reg[BIT_W-1:0]];
    assign shifted   = LIM_W'(cfg.eff_size) << step_reg;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            avail[b] = !rd_word[b]
                && (COUNT_W'({word_reg, BIT_W'(b)}) < cfg.eff_count);
        end
        found     = 1'b0;
        found_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                found     = 1'b1;
                found_bit = BIT_W'(b);
            end
        end
        cand_slot  = COUNT_W'({word_reg, found_bit});
        next_start = NS_W'({word_reg, BIT_W'(0)}) + NS_W'(WORD_W);
        scan_end   = (word_reg == LAST_WORD) || (next_start >= NS_W'(cfg.eff_count));
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        word_next   = word_reg;
        slot_next   = slot_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        pop         = 1'b0;
        raddr       = word_reg;
        mem_we      = 1'b0;
        mem_waddr   = word_reg;
        mem_wdata   = rd_word;
        fire        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_ALLOC:
                        begin
                            word_next  = '0;
                            state_next = ST_SCAN_RD;
                        end
                        OP_FREE:
                        begin
                            rem_next   = head.offset;
                            slot_next  = '0;
                            step_next  = STEP_W'(DIV_STEPS - 1);
                            state_next = ST_DIV;
                        end
                        OP_ALLOC_MISS:
                        begin
                            status_next = RSP_ALLOC_FB;
                            state_next  = ST_RESP;
                        end
                        OP_FREE_MISS:
                        begin
                            status_next = RSP_FREE_FB;
                            state_next  = ST_RESP;
                        end
                        default:
                        begin
                            status_next = RSP_IGNORED;
                            state_next  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                raddr      = word_reg;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (found)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = word_reg;
                    mem_wdata   = rd_word | (WORD_W'(1) << found_bit);
                    slot_next   = cand_slot;
                    status_next = RSP_GIVEN;
                    state_next  = ST_MUL;
                end
                else if (scan_end)
                begin
                    status_next = RSP_ALLOC_FB;
                    state_next  = ST_RESP;
                end
                else
                begin
                    word_next  = word_reg + WORD_AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MUL:
            begin
                prod_next  = LIM_W'(LIM_W'(slot_reg) * LIM_W'(cfg.eff_size));
                state_next = ST_RESP;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_reg >= shifted)
                begin
                    rem_next            = rem_reg - shifted;
                    slot_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                begin
                    state_next = ST_FREE_RD;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_FREE_RD:
            begin
                raddr      = slot_word;
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                if (free_bit)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = slot_word;
                    mem_wdata   = rd_word & ~(WORD_W'(1) << slot_reg[BIT_W-1:0]);
                    status_next = RSP_FREED;
                end
                else
                begin
                    status_next = RSP_FREE_FB;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next        = used_reg;
        alloc_total_next = alloc_total_reg;
        free_total_next  = free_total_reg;
        alloc_hit_next   = alloc_hit_reg;
        alloc_miss_next  = alloc_miss_reg;
        free_hit_next    = free_hit_reg;
        free_miss_next   = free_miss_reg;
        case (status_reg)
            RSP_GIVEN:
            begin
                used_next        = used_reg + COUNT_W'(1);
                alloc_total_next = alloc_total_reg + STAT_W'(1);
                alloc_hit_next   = alloc_hit_reg + STAT_W'(1);
            end
            RSP_ALLOC_FB:
            begin
                alloc_total_next = alloc_total_reg + STAT_W'(1);
                alloc_miss_next  = alloc_miss_reg + STAT_W'(1);
            end
            RSP_FREED:
            begin
                if (used_reg != '0)
                begin
                    used_next = used_reg - COUNT_W'(1);
                end
                free_total_next = free_total_reg + STAT_W'(1);
                free_hit_next   = free_hit_reg + STAT_W'(1);
            end
            RSP_FREE_FB:
            begin
                free_total_next = free_total_reg + STAT_W'(1);
                free_miss_next  = free_miss_reg + STAT_W'(1);
            end
            default:
            begin
                used_next = used_reg;
            end
        endcase

        rsp_next.status           = status_reg;
        rsp_next.slot_address     = (status_reg == RSP_GIVEN)
            ? ((cfg.base + ADDR_W'(prod_reg)) & ADDR_MASK) : '0;
        rsp_next.slot_index       = ((status_reg == RSP_GIVEN) || (status_reg == RSP_FREED))
            ? slot_reg[IDX_OUT_W-1:0] : '0;
        rsp_next.slots_in_use     = used_next;
        rsp_next.alloc_total      = alloc_total_next;
        rsp_next.free_total       = free_total_next;
        rsp_next.alloc_hit_total  = alloc_hit_next;
        rsp_next.alloc_miss_total = alloc_miss_next;
        rsp_next.free_hit_total   = free_hit_next;
        rsp_next.free_miss_total  = free_miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rsp_valid_reg   <= 1'b0;
            word_valid_reg  <= '0;
            rd_valid_reg    <= 1'b0;
            used_reg        <= '0;
            alloc_total_reg <= '0;
            free_total_reg  <= '0;
            alloc_hit_reg   <= '0;
            alloc_miss_reg  <= '0;
            free_hit_reg    <= '0;
            free_miss_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= word_valid_reg[raddr];
            if (mem_we)
            begin
                word_valid_reg[mem_waddr] <= 1'b1;
            end
            if (fire)
            begin
                rsp_valid_reg   <= 1'b1;
                used_reg        <= used_next;
                alloc_total_reg <= alloc_total_next;
                free_total_reg  <= free_total_next;
                alloc_hit_reg   <= alloc_hit_next;
                alloc_miss_reg  <= alloc_miss_next;
                free_hit_reg    <= free_hit_next;
                free_miss_reg   <= free_miss_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        word_reg   <= word_next;
        slot_reg   <= slot_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        prod_reg   <= prod_next;
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[raddr];
    end

    `SBA_ASSERT_ALWAYS(a_alloc_tally, clk, rst_n, (alloc_hit_reg + alloc_miss_reg) == alloc_total_reg)
    `SBA_ASSERT_ALWAYS(a_free_tally, clk, rst_n, (free_hit_reg + free_miss_reg) == free_total_reg)
    `SBA_ASSERT_IMP(a_rsp_from_resp, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == ST_RESP)
    `SBA_ASSERT_NXT(a_div_runs, clk, rst_n, (state_reg == ST_DIV) && (step_reg != '0), state_reg == ST_DIV)
    `SBA_ASSERT_IMP(a_write_state, clk, rst_n, mem_we, (state_reg == ST_SCAN_CHK) || (state_reg == ST_FREE_CHK))

endmodule

// File: tb/sv/slot_alloc_monitor.sv
// response checker for the slot bitmap allocator: tracks the slot map and counters
// from the accepted request and config beats and compares every response beat
// depends on sba_pkg
module slot_alloc_monitor #(
    parameter int unsigned MAX_SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  sba_pkg::in_item_t             req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  sba_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sba_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            pending
);
    import sba_pkg::*;

    logic [MAX_SLOTS-1:0] used_map;
    logic [COUNT_W-1:0]   used_cnt;
    logic [STAT_W-1:0]    n_alloc;
    logic [STAT_W-1:0]    n_free;
    logic [STAT_W-1:0]    n_alloc_hit;
    logic [STAT_W-1:0]    n_alloc_miss;
    logic [STAT_W-1:0]    n_free_hit;
    logic [STAT_W-1:0]    n_free_miss;
    logic [SIZE_W-1:0]    slot_bytes;
    logic [COUNT_W-1:0]   slot_count;
    logic [ADDR_W-1:0]    arena_base;
    rsp_t                 awaited_rsp[$];

    // applies one request to the tracked state and returns the response it must give
    function automatic rsp_t allocator_outcome(input in_item_t item);
        rsp_t            r;
        longint unsigned esize;
        longint unsigned ecount;
        longint unsigned slot;
        r = '0;
        esize = ((slot_bytes == '0 ? 64'd1 : 64'(slot_bytes)) + 64'd7) & ~64'd7;
        ecount = (slot_count > MAX_SLOTS) ? 64'(MAX_SLOTS) : 64'(slot_count);
        if (item.kind == KIND_ALLOC)
        begin
            n_alloc++;
            r.status = RSP_ALLOC_FB;
            if (64'(item.request_size) <= esize)
            begin
                for (longint unsigned i = 0; i < ecount; i++)
                begin
                    if (!used_map[i])
                    begin
                        used_map[i] = 1'b1;
                        used_cnt++;
                        n_alloc_hit++;
                        r.status = RSP_GIVEN;
                        r.slot_address = ADDR_W'(64'(arena_base) + i * esize);
                        r.slot_index = IDX_OUT_W'(i);
                        break;
                    end
                end
            end
            if (r.status == RSP_ALLOC_FB)
            begin
                n_alloc_miss++;
            end
        end
        else if (item.address == '0)
        begin
            r.status = RSP_IGNORED;
        end
        else
        begin
            n_free++;
            r.status = RSP_FREE_FB;
            if (item.address >= arena_base)
            begin
                slot = 64'(item.address - arena_base) / esize;
                if (slot < ecount)
                begin
                    if (used_map[slot])
                    begin
                        used_map[slot] = 1'b0;
                        if (used_cnt != '0)
                        begin
                            used_cnt--;
                        end
                        n_free_hit++;
                        r.status = RSP_FREED;
                        r.slot_index = IDX_OUT_W'(slot);
                    end
                end
            end
            if (r.status == RSP_FREE_FB)
            begin
                n_free_miss++;
            end
        end
        r.slots_in_use = used_cnt;
        r.alloc_total = n_alloc;
        r.free_total = n_free;
        r.alloc_hit_total = n_alloc_hit;
        r.alloc_miss_total = n_alloc_miss;
        r.free_hit_total = n_free_hit;
        r.free_miss_total = n_free_miss;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            used_map = '0;
            used_cnt = '0;
            n_alloc = '0;
            n_free = '0;
            n_alloc_hit = '0;
            n_alloc_miss = '0;
            n_free_hit = '0;
            n_free_miss = '0;
            slot_bytes = SIZE_W'(128);
            slot_count = COUNT_W'(256);
            arena_base = '0;
            awaited_rsp.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SLOT_SIZE:  slot_bytes = cfg_data[SIZE_W-1:0];
                    REG_SLOT_COUNT: slot_count = cfg_data[COUNT_W-1:0];
                    REG_ARENA_BASE: arena_base = cfg_data;
                    default:        ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                awaited_rsp.push_back(allocator_outcome(req));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    flag_error("response beat with nothing outstanding");
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    check_field("status", 64'(want.status), 64'(rsp.status));
                    check_field("slot_address", 64'(want.slot_address), 64'(rsp.slot_address));
                    check_field("slot_index", 64'(want.slot_index), 64'(rsp.slot_index));
                    check_field("slots_in_use", 64'(want.slots_in_use), 64'(rsp.slots_in_use));
                    check_field("alloc_total", 64'(want.alloc_total), 64'(rsp.alloc_total));
                    check_field("free_total", 64'(want.free_total), 64'(rsp.free_total));
                    check_field("alloc_hit_total", 64'(want.alloc_hit_total),
                                64'(rsp.alloc_hit_total));
                    check_field("alloc_miss_total", 64'(want.alloc_miss_total),
                                64'(rsp.alloc_miss_total));
                    check_field("free_hit_total", 64'(want.free_hit_total),
                                64'(rsp.free_hit_total));
                    check_field("free_miss_total", 64'(want.free_miss_total),
                                64'(rsp.free_miss_total));
                end
            end
        end
        pending = awaited_rsp.size();
    end

endmodule

// File: tb/sv/testbench.sv
// top of the slot bitmap allocator bench: clock, reset, request and config stimulus,
// watchdog and verdict; checking lives in slot_alloc_monitor
// depends on sba_pkg, slot_bitmap_allocator_core and slot_alloc_monitor
module testbench;
    import sba_pkg::*;

    localparam int unsigned SLOTS       = 256;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          SEG_ITEMS   = 145;
    localparam int          NUM_SEGS    = 9;
    // unmapped register index, writes to it are dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int SEG_SLOT_SIZE[NUM_SEGS]  = '{8, 4096, 1, 8191, 24, 100, 0, 16, 4095};
    localparam int SEG_SLOT_COUNT[NUM_SEGS] = '{16, 256, 5, 511, 1, 64, 12, 200, 3};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    in_item_t             req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    int mismatches;
    int pending;
    int tx_idle_pct = 10;
    int rx_idle_pct = 73;
    int stall_cycles = 0;

    // config as the stimulus sees it, used to aim frees at real slots
    longint unsigned gen_size = 128;
    longint unsigned gen_count = 256;
    longint unsigned gen_base = 0;

    always #4 clk = ~clk;

    slot_bitmap_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slot_alloc_monitor #(
        .MAX_SLOTS (SLOTS)
    ) u_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    function automatic in_item_t alloc_req(input logic [REQ_W-1:0] bytes);
        in_item_t item;
        item = '0;
        item.kind = KIND_ALLOC;
        item.request_size = bytes;
        return item;
    endfunction

    function automatic in_item_t free_req(input logic [ADDR_W-1:0] addr);
        in_item_t item;
        item = '0;
        item.kind = KIND_FREE;
        item.address = addr;
        return item;
    endfunction

    // mostly well-aimed allocs and frees, with some junk and out-of-arena addresses
    function automatic in_item_t random_item();
        in_item_t        item;
        int              pick;
        longint unsigned idx;
        longint unsigned spot;
        item.kind = ($urandom_range(0, 1) == 0) ? KIND_ALLOC : KIND_FREE;
        item.request_size = $urandom();
        item.address = rand48();
        pick = $urandom_range(0, 99);
        if (item.kind == KIND_ALLOC)
        begin
            if (pick < 80)
            begin
                item.request_size = $urandom_range(0, 32'(gen_size));
            end
            else if (pick < 88)
            begin
                item.request_size = REQ_W'(gen_size);
            end
            else if (pick < 94)
            begin
                item.request_size = REQ_W'(gen_size + 1);
            end
        end
        else if (pick < 65 && gen_count != 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                idx = $urandom_range(0, 32'(gen_count - 1));
            end
            else
            begin
                idx = $urandom_range(0, 32'((gen_count < 12 ? gen_count : 12) - 1));
            end
            spot = gen_base + idx * gen_size + $urandom_range(0, 32'(gen_size - 1));
            item.address = spot[ADDR_W-1:0];
        end
        else if (pick < 72)
        begin
            item.address = '0;
        end
        else if (pick < 80)
        begin
            spot = gen_base - $urandom_range(1, 4096);
            item.address = spot[ADDR_W-1:0];
        end
        else if (pick < 88)
        begin
            spot = gen_base + gen_count * gen_size + $urandom_range(0, 65535);
            item.address = spot[ADDR_W-1:0];
        end
        return item;
    endfunction

    task automatic send_item(input in_item_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // hold requests back until every outstanding response has come out
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // unused upper data bits carry junk so the register masking gets exercised
    task automatic apply_config(input int slot_bytes, input int slots,
                                input logic [ADDR_W-1:0] base, input bit spare);
        logic [ADDR_W-1:0] word;
        wait_idle();
        word = rand48();
        word[SIZE_W-1:0] = slot_bytes[SIZE_W-1:0];
        write_reg(REG_SLOT_SIZE, word);
        word = rand48();
        word[COUNT_W-1:0] = slots[COUNT_W-1:0];
        write_reg(REG_SLOT_COUNT, word);
        write_reg(REG_ARENA_BASE, base);
        if (spare)
        begin
            write_reg(REG_SPARE, rand48());
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_size = ((slot_bytes == 0 ? 1 : slot_bytes) + 7) & ~7;
        gen_count = (slots > SLOTS) ? SLOTS : slots;
        gen_base = base;
    endtask

    initial
    begin
        logic [ADDR_W-1:0] seg_base;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset config: 128-byte slots, 256 slots, base 0
        send_item(alloc_req(32'd0));
        send_item(alloc_req(32'd128));
        send_item(alloc_req(32'd129));
        send_item(alloc_req(32'hFFFF_FFFF));
        send_item(free_req(48'd0));
        send_item(free_req(48'd128));
        send_item(free_req(48'd128));
        send_item(free_req(48'd5));
        send_item(free_req(48'hFFFF_FFFF_FFFF));
        send_item(alloc_req(32'd1));

        // zero size means 8 bytes; base near the top so slot 1 wraps to address 0
        apply_config(0, 2, 48'hFFFF_FFFF_FFF8, 1'b1);
        send_item(alloc_req(32'd8));
        send_item(alloc_req(32'd0));
        send_item(alloc_req(32'd9));
        send_item(free_req(48'h10));
        send_item(free_req(48'hFFFF_FFFF_FFFF));
        send_item(alloc_req(32'd0));

        // no slots at all
        apply_config(1, 0, '0, 1'b0);
        send_item(alloc_req(32'd0));
        send_item(free_req(48'd8));

        // largest slot size, count above the built maximum
        apply_config(8191, 511, '0, 1'b0);
        send_item(alloc_req(32'd8192));
        send_item(alloc_req(32'd8193));
        send_item(free_req(48'd24575));
        send_item(free_req(48'd2097152));

        // shrink to one slot while slot 1 is still marked used
        apply_config(4096, 1, '0, 1'b0);
        send_item(alloc_req(32'd1));
        send_item(free_req(48'd4096));
        send_item(free_req(48'd4095));

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg / 3)
                0:
                begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 73;
                end
                1:
                begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 10;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (seg == 0)
            begin
                seg_base = '0;
            end
            else if (seg == 3)
            begin
                seg_base = '1;
            end
            else
            begin
                seg_base = rand48();
            end
            apply_config(SEG_SLOT_SIZE[seg], SEG_SLOT_COUNT[seg], seg_base, 1'b0);
            repeat (SEG_ITEMS)
            begin
                if ($urandom_range(0, 59) == 0)
                begin
                    wait_idle();
                end
                send_item(random_item());
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sba_pkg.sv
hw/rtl/sba_cfg.sv
hw/rtl/sba_front.sv
hw/rtl/sba_queue.sv
hw/rtl/sba_back.sv
hw/rtl/slot_bitmap_allocator_core.sv
tb/sv/slot_alloc_monitor.sv
tb/sv/testbench.sv
